### design/smsort_pkg.sv
// Shared constants, types and codes of the stable merge sort by key block.
package smsort_pkg;

    localparam int CAPACITY = 1024;
    localparam int KEY_BITS = 12;
    localparam int TAG_BITS = 10;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Action codes of an input transaction
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // Status codes of a result transaction
    localparam logic [1:0] ST_RECORD = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_TRUNC  = 2'd2;

    typedef logic [KEY_BITS-1:0] t_key;
    typedef logic [TAG_BITS-1:0] t_tag;
    typedef logic [CNT_W-1:0]    t_cnt;

    typedef struct packed {
        logic valid;
        t_key key;
        t_tag tag;
    } t_rec;

    typedef struct packed {
        logic insert;   // place the new record after all keys <= its key
        logic shift;    // move every record one cell toward the head
        logic clear;    // treat the row as empty before this insert
    } t_cmd;

endpackage

### design/smsort_if.sv
// Valid/ready channel interfaces for load/read requests and sorted results.
interface smsort_in_if;
    logic                 valid;
    logic                 ready;
    logic                 action;
    smsort_pkg::t_key     sort_key;
    smsort_pkg::t_tag     record_tag;
    logic                 final_load;

    modport source (output valid, action, sort_key, record_tag, final_load, input ready);
    modport sink   (input valid, action, sort_key, record_tag, final_load, output ready);
endinterface

interface smsort_out_if;
    logic                 valid;
    logic                 ready;
    smsort_pkg::t_key     out_key;
    smsort_pkg::t_tag     out_tag;
    logic                 final_out;
    logic [1:0]           status;

    modport source (output valid, out_key, out_tag, final_out, status, input ready);
    modport sink   (input valid, out_key, out_tag, final_out, status, output ready);
endinterface

### design/smsort_cell.sv
// One cell of the sorting row: holds one record, inserts or shifts with its neighbors.
module smsort_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  smsort_pkg::t_cmd i_cmd,
    input  smsort_pkg::t_key i_new_key,
    input  smsort_pkg::t_tag i_new_tag,
    input  smsort_pkg::t_rec i_prev,
    input  logic             i_prev_le,
    input  smsort_pkg::t_rec i_next,
    output smsort_pkg::t_rec o_rec,
    output logic             o_le
);

    logic             r_valid;
    smsort_pkg::t_key r_key;
    smsort_pkg::t_tag r_tag;
    logic             n_valid;
    smsort_pkg::t_key n_key;
    smsort_pkg::t_tag n_tag;
    logic             w_valid;

    assign w_valid = r_valid & ~i_cmd.clear;
    assign o_rec   = '{valid: w_valid, key: r_key, tag: r_tag};
    // Equal keys count as "before": the new record lands after them (stable)
    assign o_le    = w_valid & (r_key <= i_new_key);

    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        n_tag   = r_tag;
        if (i_cmd.insert) begin
            if (o_le) begin
                n_valid = w_valid;
            end else if (i_prev_le) begin
                n_valid = 1'b1;
                n_key   = i_new_key;
                n_tag   = i_new_tag;
            end else begin
                n_valid = i_prev.valid;
                n_key   = i_prev.key;
                n_tag   = i_prev.tag;
            end
        end else if (i_cmd.shift) begin
            n_valid = i_next.valid;
            n_key   = i_next.key;
            n_tag   = i_next.tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_key <= n_key;
        r_tag <= n_tag;
    end

endmodule

### design/stable_merge_sort_by_key.sv
// Top level of the stable key sorter: a row of record cells plus set control.
//
// Records are kept sorted as they arrive: every load transaction inserts its
// record into a row of CAPACITY cells, each cell comparing its key with the
// new one and either holding, taking the new record or taking its left
// neighbor's record, so equal keys keep load order. A load marked final
// closes the set; no separate sort phase follows. Each read transaction
// returns the head cell and shifts the row one place toward the head. Each
// transaction is done by the single insert/shift step of the cell row; the
// block accepts a new transaction in every cycle in which the result
// register is free or being taken. Loads beyond CAPACITY are dropped and the
// reads of that set report a truncated status; reads before a set is closed
// or past its end report nothing to read. The first load after a closed set
// starts a new set.
module stable_merge_sort_by_key (
    input  logic         i_clk,
    input  logic         i_rst_n,
    smsort_in_if.sink    i_in,
    smsort_out_if.source o_out
);

    smsort_pkg::t_rec w_rec [smsort_pkg::CAPACITY];
    logic             w_le  [smsort_pkg::CAPACITY];
    smsort_pkg::t_cmd w_cmd;

    logic             r_done;
    logic             r_ovf;
    smsort_pkg::t_cnt r_count;
    smsort_pkg::t_cnt r_rdptr;
    logic             n_done;
    logic             n_ovf;
    smsort_pkg::t_cnt n_count;
    smsort_pkg::t_cnt n_rdptr;

    logic             r_oval;
    smsort_pkg::t_key r_okey;
    smsort_pkg::t_tag r_otag;
    logic             r_ofinal;
    logic [1:0]       r_ostat;

    logic             w_accept;
    logic             w_load;
    logic             w_read;
    logic             w_restart;
    logic             w_has_rec;
    smsort_pkg::t_cnt w_base;

    // Take a transaction whenever the result register can be refilled
    assign i_in.ready = ~r_oval | o_out.ready;
    assign w_accept   = i_in.valid & i_in.ready;
    assign w_load     = w_accept & (i_in.action == smsort_pkg::ACT_LOAD);
    assign w_read     = w_accept & (i_in.action == smsort_pkg::ACT_READ);

    // A load after a closed set begins a new one
    assign w_restart  = w_load & r_done;
    assign w_base     = r_done ? '0 : r_count;
    assign w_has_rec  = r_done & (r_rdptr < r_count);

    assign w_cmd.insert = w_load & (w_base < smsort_pkg::t_cnt'(smsort_pkg::CAPACITY));
    assign w_cmd.shift  = w_read & w_has_rec;
    assign w_cmd.clear  = w_restart;

    // Row of cells; the head has an always-satisfied left boundary
    for (genvar g = 0; g < smsort_pkg::CAPACITY; g++) begin : g_cell
        smsort_pkg::t_rec w_prev;
        smsort_pkg::t_rec w_next;
        logic             w_prev_le;

        if (g == 0) begin : g_head
            assign w_prev    = '0;
            assign w_prev_le = 1'b1;
        end else begin : g_body
            assign w_prev    = w_rec[g-1];
            assign w_prev_le = w_le[g-1];
        end

        if (g == smsort_pkg::CAPACITY - 1) begin : g_tail
            assign w_next = '0;
        end else begin : g_inner
            assign w_next = w_rec[g+1];
        end

        smsort_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cmd     (w_cmd),
            .i_new_key (i_in.sort_key),
            .i_new_tag (i_in.record_tag),
            .i_prev    (w_prev),
            .i_prev_le (w_prev_le),
            .i_next    (w_next),
            .o_rec     (w_rec[g]),
            .o_le      (w_le[g])
        );
    end

    // Set bookkeeping: count, read position, overflow and closed flag
    always_comb begin
        n_done  = r_done;
        n_ovf   = r_ovf;
        n_count = r_count;
        n_rdptr = r_rdptr;
        if (w_load) begin
            n_count = w_cmd.insert ? w_base + 1'b1 : w_base;
            n_ovf   = (r_ovf & ~r_done) | ~w_cmd.insert;
            n_done  = i_in.final_load;
            n_rdptr = '0;
        end else if (w_cmd.shift) begin
            n_rdptr = r_rdptr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done  <= 1'b0;
            r_ovf   <= 1'b0;
            r_count <= '0;
            r_rdptr <= '0;
        end else begin
            r_done  <= n_done;
            r_ovf   <= n_ovf;
            r_count <= n_count;
            r_rdptr <= n_rdptr;
        end
    end

    // Result register: filled by a read, drained by the sink
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oval <= 1'b0;
        end else if (w_read) begin
            r_oval <= 1'b1;
        end else if (o_out.ready) begin
            r_oval <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_read) begin
            if (w_has_rec) begin
                r_okey   <= w_rec[0].key;
                r_otag   <= w_rec[0].tag;
                r_ofinal <= (r_rdptr + 1'b1) == r_count;
                r_ostat  <= r_ovf ? smsort_pkg::ST_TRUNC : smsort_pkg::ST_RECORD;
            end else begin
                r_okey   <= '0;
                r_otag   <= '0;
                r_ofinal <= 1'b0;
                r_ostat  <= smsort_pkg::ST_EMPTY;
            end
        end
    end

    assign o_out.valid     = r_oval;
    assign o_out.out_key   = r_okey;
    assign o_out.out_tag   = r_otag;
    assign o_out.final_out = r_ofinal;
    assign o_out.status    = r_ostat;

endmodule
